/* src/sct_pkg.sv */
// ----------------------------------------------------------------------------
// Strata counter table package
// Shared field widths, item kinds and configuration register indexes.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int unsigned StratumW  = 6;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned UsedW     = 7;
  localparam int unsigned MatchW    = 38;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 38;

  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_INC   = 2'd1,
    KIND_DEC   = 2'd2,
    KIND_QUERY = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_STRATA  = 1'b0,
    CFG_MAX_MATCHES = 1'b1
  } cfg_idx_e;

  localparam logic [MatchW-1:0] MaxMatchesRst = '1;

endpackage

/* src/sct_req_if.sv */
// ----------------------------------------------------------------------------
// Strata counter table request channel
// Valid/ready channel that carries one update or query item.
// ----------------------------------------------------------------------------
interface sct_req_if import sct_pkg::*; ();

  logic                valid;
  logic                ready;
  kind_e               kind;
  logic [StratumW-1:0] stratum;
  logic [ValueW-1:0]   value;
  logic [StratumW-1:0] begin_stratum;

  modport source (output valid, kind, stratum, value, begin_stratum, input ready);
  modport sink   (input valid, kind, stratum, value, begin_stratum, output ready);

endinterface

/* src/sct_rsp_if.sv */
// ----------------------------------------------------------------------------
// Strata counter table result channel
// Valid/ready channel that carries the table summary for one item.
// ----------------------------------------------------------------------------
interface sct_rsp_if import sct_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [ValueW-1:0]   counter_value;
  logic [UsedW-1:0]    strata_in_use;
  logic                next_found;
  logic [StratumW-1:0] next_stratum;
  logic                uniq_found;
  logic [StratumW-1:0] uniq_gap;
  logic                min_found;
  logic [UsedW-1:0]    min_strata;
  logic [UsedW-1:0]    decode_strata;
  logic [MatchW-1:0]   decode_matches;
  logic [MatchW-1:0]   total_matches;
  logic                index_error;

  modport source (
    output valid, counter_value, strata_in_use, next_found, next_stratum, uniq_found,
           uniq_gap, min_found, min_strata, decode_strata, decode_matches,
           total_matches, index_error,
    input  ready
  );
  modport sink (
    input  valid, counter_value, strata_in_use, next_found, next_stratum, uniq_found,
           uniq_gap, min_found, min_strata, decode_strata, decode_matches,
           total_matches, index_error,
    output ready
  );

endinterface

/* src/strata_counter_table_unit.sv */
// ----------------------------------------------------------------------------
// Strata counter table unit
// Per-stratum match counters in a synchronous memory. Each in-range update
// writes one counter, then a scan over the used strata builds the table summary.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake       Contents
//  req_i     in         valid/ready     kind, stratum, value, begin_stratum
//  rsp_o     out        valid/ready     counter summary, one per request
//  cfg       in         cfg_we_i        decode strata floor, decode match limit
//
//  An update passes through a read-modify-write state, a scan of the used
//  strata through the single memory read port, and a final state that loads
//  the result. Queries and out-of-range updates skip the write state. The next
//  request is taken after the result is loaded, so the used count sets the
//  time.
//  Reset clears the valid bits and the used count; no memory clearing pass.
//  A stalled result sits in the output register while the next request is
//  taken; the unit waits in its final state only if that register is full.
// ----------------------------------------------------------------------------
module strata_counter_table_unit import sct_pkg::*; #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sct_req_if.sink             req_i,
  sct_rsp_if.source           rsp_o
);

  // Only strata reachable by the 6-bit index are ever stored.
  localparam int unsigned MemD  = (DEPTH < 2 ** StratumW) ? DEPTH : 2 ** StratumW;
  localparam int unsigned AddrW = $clog2(MemD);
  localparam int unsigned SumW  = (COUNT_WIDTH + StratumW > 64) ? 64
                                                                : COUNT_WIDTH + StratumW;
  localparam int unsigned CmpW  = (SumW > MatchW) ? SumW : MatchW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [ValueW-1:0]   counter_value;
    logic [UsedW-1:0]    strata_in_use;
    logic                next_found;
    logic [StratumW-1:0] next_stratum;
    logic                uniq_found;
    logic [StratumW-1:0] uniq_gap;
    logic                min_found;
    logic [UsedW-1:0]    min_strata;
    logic [UsedW-1:0]    decode_strata;
    logic [MatchW-1:0]   decode_matches;
    logic [MatchW-1:0]   total_matches;
    logic                index_error;
  } res_t;

  state_e                 state_q;
  kind_e                  kind_q;
  logic [StratumW-1:0]    strat_q;
  logic [ValueW-1:0]      value_q;
  logic [StratumW-1:0]    begin_q;
  logic                   err_q;
  logic [UsedW-1:0]       used_q;
  logic [UsedW-1:0]       min_q;
  logic [MatchW-1:0]      max_q;
  logic [MemD-1:0]        vld_q;

  logic [COUNT_WIDTH-1:0] mem_q [MemD];
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic                   rvld_q;

  logic [UsedW-1:0]       rd_idx_q;
  logic                   pend_q;
  logic [UsedW-1:0]       pidx_q;

  logic                   nf_q;
  logic [StratumW-1:0]    ns_q;
  logic [ValueW-1:0]      cval_q;
  logic                   mf_q;
  logic [UsedW-1:0]       ms_q;
  logic                   uend_q;
  logic                   useen_q;
  logic [StratumW-1:0]    ud_q;
  logic                   cut_q;
  logic [UsedW-1:0]       strata_q;
  logic [UsedW-1:0]       ds_q;
  logic [SumW-1:0]        acc_q;
  logic [SumW-1:0]        tot_q;

  logic                   rsp_vld_q;
  res_t                   res_q;

  logic                   req_acc;
  logic                   req_err;
  logic [AddrW-1:0]       raddr;
  logic                   mem_we;
  logic [COUNT_WIDTH-1:0] old_cnt;
  logic [COUNT_WIDTH-1:0] new_cnt;
  logic [COUNT_WIDTH-1:0] cur_c;
  logic                   c_nz;
  logic [SumW-1:0]        sum_ac;
  logic [UsedW-1:0]       strata_n;
  logic                   cut_now;
  logic                   res_free;
  res_t                   res_d;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign req_err     = (req_i.kind != KIND_QUERY) &&
                       (32'(req_i.stratum) >= 32'(DEPTH));

  assign raddr  = (state_q == ST_SCAN) ? rd_idx_q[AddrW-1:0] : req_i.stratum[AddrW-1:0];
  assign mem_we = (state_q == ST_UPD);

  // Entries never written since reset read as zero.
  assign old_cnt = rvld_q ? rdata_q : '0;
  assign cur_c   = old_cnt;
  assign c_nz    = (cur_c != '0);

  always_comb begin
    case (kind_q)
      KIND_SET: new_cnt = COUNT_WIDTH'(value_q);
      KIND_INC: new_cnt = old_cnt + COUNT_WIDTH'(1);
      KIND_DEC: new_cnt = old_cnt - COUNT_WIDTH'(1);
      default:  new_cnt = old_cnt;
    endcase
  end

  assign sum_ac   = acc_q + SumW'(cur_c);
  assign strata_n = (c_nz || (strata_q != '0)) ? strata_q + UsedW'(1) : strata_q;
  assign cut_now  = (CmpW'(sum_ac) > CmpW'(max_q)) && (strata_n > min_q);

  assign res_free = !rsp_vld_q || rsp_o.ready;

  always_comb begin
    res_d.counter_value  = cval_q;
    res_d.strata_in_use  = used_q;
    res_d.next_found     = nf_q;
    res_d.next_stratum   = ns_q;
    res_d.uniq_found     = useen_q;
    res_d.uniq_gap       = useen_q ? ud_q : '0;
    res_d.min_found      = mf_q;
    res_d.min_strata     = ms_q;
    res_d.decode_strata  = cut_q ? ds_q : used_q;
    res_d.decode_matches = MatchW'(acc_q);
    res_d.total_matches  = MatchW'(tot_q);
    res_d.index_error    = err_q;
  end

  // Counter memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[strat_q[AddrW-1:0]] <= new_cnt;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      kind_q    <= KIND_QUERY;
      strat_q   <= '0;
      value_q   <= '0;
      begin_q   <= '0;
      err_q     <= 1'b0;
      used_q    <= '0;
      min_q     <= '0;
      max_q     <= MaxMatchesRst;
      vld_q     <= '0;
      rvld_q    <= 1'b0;
      rd_idx_q  <= '0;
      pend_q    <= 1'b0;
      pidx_q    <= '0;
      nf_q      <= 1'b0;
      ns_q      <= '0;
      cval_q    <= '0;
      mf_q      <= 1'b0;
      ms_q      <= '0;
      uend_q    <= 1'b0;
      useen_q   <= 1'b0;
      ud_q      <= '0;
      cut_q     <= 1'b0;
      strata_q  <= '0;
      ds_q      <= '0;
      acc_q     <= '0;
      tot_q     <= '0;
      rsp_vld_q <= 1'b0;
      res_q     <= '0;
    end else begin
      rvld_q <= vld_q[raddr];

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_MIN_STRATA:  min_q <= cfg_data_i[UsedW-1:0];
          CFG_MAX_MATCHES: max_q <= cfg_data_i[MatchW-1:0];
          default: ;
        endcase
      end

      // The final state reloads the register itself when the old result leaves.
      if (rsp_vld_q && rsp_o.ready && (state_q != ST_FIN)) begin
        rsp_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            kind_q   <= req_i.kind;
            strat_q  <= req_i.stratum;
            value_q  <= req_i.value;
            begin_q  <= req_i.begin_stratum;
            err_q    <= req_err;
            rd_idx_q <= '0;
            pend_q   <= 1'b0;
            nf_q     <= 1'b0;
            ns_q     <= '0;
            cval_q   <= '0;
            mf_q     <= 1'b0;
            ms_q     <= '0;
            uend_q   <= 1'b0;
            useen_q  <= 1'b0;
            ud_q     <= '0;
            cut_q    <= 1'b0;
            strata_q <= '0;
            ds_q     <= '0;
            acc_q    <= '0;
            tot_q    <= '0;
            state_q  <= (req_err || (req_i.kind == KIND_QUERY)) ? ST_SCAN : ST_UPD;
          end
        end

        ST_UPD: begin
          vld_q[strat_q[AddrW-1:0]] <= 1'b1;
          cval_q <= ValueW'(new_cnt);
          if (used_q < UsedW'(strat_q) + UsedW'(1)) begin
            used_q <= UsedW'(strat_q) + UsedW'(1);
          end
          state_q <= ST_SCAN;
        end

        ST_SCAN: begin
          if (rd_idx_q < used_q) begin
            rd_idx_q <= rd_idx_q + UsedW'(1);
            pend_q   <= 1'b1;
            pidx_q   <= rd_idx_q;
          end else begin
            pend_q <= 1'b0;
          end

          if (pend_q) begin
            tot_q <= tot_q + SumW'(cur_c);

            if (!nf_q && (pidx_q >= UsedW'(begin_q)) && c_nz) begin
              nf_q <= 1'b1;
              ns_q <= pidx_q[StratumW-1:0];
              if (kind_q == KIND_QUERY) begin
                cval_q <= ValueW'(cur_c);
              end
            end

            if (!mf_q && c_nz) begin
              mf_q <= 1'b1;
              ms_q <= pidx_q + UsedW'(1);
            end

            // The degree counts empty strata after a lone single match.
            if (!uend_q) begin
              if (!c_nz) begin
                if (useen_q) begin
                  ud_q <= ud_q + StratumW'(1);
                end
              end else if ((cur_c == COUNT_WIDTH'(1)) && !useen_q) begin
                useen_q <= 1'b1;
              end else begin
                uend_q <= 1'b1;
              end
            end

            if (!cut_q) begin
              strata_q <= strata_n;
              if (cut_now) begin
                cut_q <= 1'b1;
                ds_q  <= pidx_q;
              end else begin
                acc_q <= sum_ac;
              end
            end
          end

          if ((rd_idx_q == used_q) && !pend_q) begin
            state_q <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (res_free) begin
            res_q     <= res_d;
            rsp_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid          = rsp_vld_q;
  assign rsp_o.counter_value  = res_q.counter_value;
  assign rsp_o.strata_in_use  = res_q.strata_in_use;
  assign rsp_o.next_found     = res_q.next_found;
  assign rsp_o.next_stratum   = res_q.next_stratum;
  assign rsp_o.uniq_found     = res_q.uniq_found;
  assign rsp_o.uniq_gap       = res_q.uniq_gap;
  assign rsp_o.min_found      = res_q.min_found;
  assign rsp_o.min_strata     = res_q.min_strata;
  assign rsp_o.decode_strata  = res_q.decode_strata;
  assign rsp_o.decode_matches = res_q.decode_matches;
  assign rsp_o.total_matches  = res_q.total_matches;
  assign rsp_o.index_error    = res_q.index_error;

  a_one_item_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_i.ready)
    else $error("request taken while an item is in progress");

  a_no_update_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> !err_q)
    else $error("counter update for an out-of-range stratum");

  a_error_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && res_q.index_error) |-> (res_q.counter_value == '0))
    else $error("nonzero counter value on an index error");

  a_decode_within_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> (res_q.decode_strata <= res_q.strata_in_use))
    else $error("decode cut beyond the used strata");

  a_min_found_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> (res_q.min_found == (res_q.min_strata != '0)))
    else $error("min_found disagrees with min_strata");

endmodule
